// File: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion violated");

// Check that a condition implies a consequence in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion violated");

// Check that a condition implies a consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion violated");

`endif

// File: hw/rtl/kvt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kvt_pkg;

   // Request operation codes
   typedef enum logic [2:0] {
      OP_INSERT   = 3'd0,
      OP_UPDATE   = 3'd1,
      OP_UPSERT   = 3'd2,
      OP_ERASE    = 3'd3,
      OP_CONTAINS = 3'd4,
      OP_GET_KEY  = 3'd5,
      OP_GET_SLOT = 3'd6
   } op_type;

   localparam int unsigned KEY_PORT_BITS   = 32;
   localparam int unsigned VALUE_PORT_BITS = 32;
   localparam int unsigned SLOT_PORT_BITS  = 8;
   localparam int unsigned COUNT_PORT_BITS = 9;

endpackage

`default_nettype wire

// File: hw/rtl/key_value_table_core.sv
// Key/value table: up to CAPACITY unique pairs kept packed in slots 0 to count-1 of one
// pair memory (key and value side by side, one write and one registered read port).
// Keyed operations (insert, update, insert-or-update, erase, contains, get by key) scan
// the packed slots one read per cycle until the first equal key (all stored pairs on a
// miss); erase of a present key adds a step to fetch the last pair that fills the freed
// slot. Get by slot reads the slot only when it is below the count, and an unused op code
// goes straight to the result step. The scan is bound by the single read port of the pair
// memory. One transaction is worked on at a time; a new request is taken while the
// previous result still waits on the response channel. Every response carries the entry
// count and an empty flag after the operation.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module key_value_table_core #(
   parameter int unsigned CAPACITY   = 256,
   parameter int unsigned KEY_BITS   = 32,
   parameter int unsigned VALUE_BITS = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire kvt_pkg::op_type                       req_op,
   input  wire logic [kvt_pkg::KEY_PORT_BITS-1:0]     req_key_in,
   input  wire logic [kvt_pkg::VALUE_PORT_BITS-1:0]   req_value_in,
   input  wire logic [kvt_pkg::SLOT_PORT_BITS-1:0]    req_slot_index,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_ok,
   output logic      [kvt_pkg::KEY_PORT_BITS-1:0]     rsp_key_out,
   output logic      [kvt_pkg::VALUE_PORT_BITS-1:0]   rsp_value_out,
   output logic      [kvt_pkg::COUNT_PORT_BITS-1:0]   rsp_entry_count,
   output logic                                       rsp_is_empty
);

   import kvt_pkg::*;

   localparam int unsigned AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
   localparam int unsigned PAIR_W = KEY_BITS + VALUE_BITS;
   localparam int unsigned CMP_W  = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ACT,
      ST_ERASE_WR,
      ST_SLOT_RD,
      ST_SLOT_DATA,
      ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   pend_ff, pend_in;
   op_type                 op_ff, op_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [VALUE_BITS-1:0]  val_ff, val_in;
   logic [SLOT_PORT_BITS-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic [AW-1:0]          pidx_ff, pidx_in;
   logic [AW-1:0]          hit_ff, hit_in;
   logic                   found_ff, found_in;
   logic                   res_ok_ff, res_ok_in;
   logic [KEY_BITS-1:0]    res_key_ff, res_key_in;
   logic [VALUE_BITS-1:0]  res_val_ff, res_val_in;
   logic                   rsp_ok_ff, rsp_ok_in;
   logic [KEY_PORT_BITS-1:0]   rsp_key_ff, rsp_key_in;
   logic [VALUE_PORT_BITS-1:0] rsp_val_ff, rsp_val_in;
   logic [COUNT_PORT_BITS-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic                   rsp_empty_ff, rsp_empty_in;

   logic                   ram_we;
   logic [AW-1:0]          ram_waddr;
   logic [PAIR_W-1:0]      ram_wdata;
   logic [AW-1:0]          ram_raddr;
   logic [PAIR_W-1:0]      ram_rdata;

   logic [KEY_BITS-1:0]    rd_key;
   logic [VALUE_BITS-1:0]  rd_val;
   logic [63:0]            key_ext;
   logic [63:0]            val_ext;
   logic [63:0]            res_key_ext;
   logic [63:0]            res_val_ext;
   logic [CNT_W+8:0]       cnt_ext;
   logic [CNT_W-1:0]       last_cnt;
   logic                   full;
   logic [CMP_W-1:0]       slot_cmp;
   logic [CMP_W-1:0]       count_cmp;

   kvt_ram #(
      .WIDTH (PAIR_W),
      .DEPTH (CAPACITY)
   ) u_pair_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Split the stored pair, fit port fields to the stored widths
   assign rd_key      = ram_rdata[PAIR_W-1 -: KEY_BITS];
   assign rd_val      = ram_rdata[VALUE_BITS-1:0];
   assign key_ext     = 64'(req_key_in);
   assign val_ext     = 64'(req_value_in);
   assign res_key_ext = 64'(res_key_ff);
   assign res_val_ext = 64'(res_val_ff);
   assign cnt_ext     = (CNT_W + 9)'(count_ff);
   assign last_cnt    = count_ff - CNT_W'(1);
   assign full        = (count_ff == CNT_W'(CAPACITY));
   assign slot_cmp    = CMP_W'(slot_ff);
   assign count_cmp   = CMP_W'(count_ff);

   assign req_ready = (state_ff == ST_IDLE);

   // Sequence scan, modify and write back of one transaction
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      pend_in      = pend_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      slot_in      = slot_ff;
      idx_in       = idx_ff;
      pidx_in      = pidx_ff;
      hit_in       = hit_ff;
      found_in     = found_ff;
      res_ok_in    = res_ok_ff;
      res_key_in   = res_key_ff;
      res_val_in   = res_val_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_empty_in = rsp_empty_ff;
      ram_we       = 1'b0;
      ram_waddr    = hit_ff;
      ram_wdata    = {key_ff, val_ff};
      ram_raddr    = idx_ff[AW-1:0];

      // Drop the response once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in      = req_op;
               key_in     = key_ext[KEY_BITS-1:0];
               val_in     = val_ext[VALUE_BITS-1:0];
               slot_in    = req_slot_index;
               idx_in     = '0;
               pend_in    = 1'b0;
               found_in   = 1'b0;
               res_ok_in  = 1'b0;
               res_key_in = '0;
               res_val_in = '0;
               unique case (req_op) inside
                  OP_INSERT, OP_UPDATE, OP_UPSERT, OP_ERASE, OP_CONTAINS, OP_GET_KEY: begin
                     state_in = ST_SCAN;
                  end
                  OP_GET_SLOT: begin
                     state_in = ST_SLOT_RD;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         // Issue one read per cycle, compare the data of the previous read
         ST_SCAN: begin
            if (pend_ff && (rd_key == key_ff)) begin
               found_in   = 1'b1;
               hit_in     = pidx_ff;
               res_val_in = rd_val;
               pend_in    = 1'b0;
               state_in   = ST_ACT;
            end else if (idx_ff < count_ff) begin
               pidx_in = idx_ff[AW-1:0];
               idx_in  = idx_ff + CNT_W'(1);
               pend_in = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = ST_ACT;
            end
         end

         // Apply the operation to the scan outcome
         ST_ACT: begin
            state_in = ST_DONE;
            if (op_ff != OP_GET_KEY) begin
               res_val_in = '0;
            end
            unique case (op_ff) inside
               OP_INSERT: begin
                  if (!found_ff && !full) begin
                     ram_we    = 1'b1;
                     ram_waddr = count_ff[AW-1:0];
                     count_in  = count_ff + CNT_W'(1);
                     res_ok_in = 1'b1;
                  end
               end
               OP_UPDATE: begin
                  if (found_ff) begin
                     ram_we    = 1'b1;
                     res_ok_in = 1'b1;
                  end
               end
               OP_UPSERT: begin
                  if (found_ff) begin
                     ram_we    = 1'b1;
                     res_ok_in = 1'b1;
                  end else if (!full) begin
                     ram_we    = 1'b1;
                     ram_waddr = count_ff[AW-1:0];
                     count_in  = count_ff + CNT_W'(1);
                     res_ok_in = 1'b1;
                  end
               end
               OP_ERASE: begin
                  if (found_ff) begin
                     ram_raddr = last_cnt[AW-1:0];
                     state_in  = ST_ERASE_WR;
                  end
               end
               OP_CONTAINS, OP_GET_KEY: begin
                  res_ok_in = found_ff;
               end
               default: begin
                  res_ok_in = 1'b0;
               end
            endcase
         end

         // Move the last pair into the freed slot
         ST_ERASE_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            count_in  = last_cnt;
            res_ok_in = 1'b1;
            state_in  = ST_DONE;
         end

         ST_SLOT_RD: begin
            ram_raddr = slot_cmp[AW-1:0];
            if (slot_cmp < count_cmp) begin
               state_in = ST_SLOT_DATA;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_SLOT_DATA: begin
            res_key_in = rd_key;
            res_val_in = rd_val;
            res_ok_in  = 1'b1;
            state_in   = ST_DONE;
         end

         // Hold the result until the response register is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_key_in   = res_key_ext[KEY_PORT_BITS-1:0];
               rsp_val_in   = res_val_ext[VALUE_PORT_BITS-1:0];
               rsp_cnt_in   = cnt_ext[COUNT_PORT_BITS-1:0];
               rsp_empty_in = (count_ff == '0);
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state, control and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
      op_ff        <= op_in;
      key_ff       <= key_in;
      val_ff       <= val_in;
      slot_ff      <= slot_in;
      idx_ff       <= idx_in;
      pidx_ff      <= pidx_in;
      hit_ff       <= hit_in;
      found_ff     <= found_in;
      res_ok_ff    <= res_ok_in;
      res_key_ff   <= res_key_in;
      res_val_ff   <= res_val_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_val_ff   <= rsp_val_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_key_out     = rsp_key_ff;
   assign rsp_value_out   = rsp_val_ff;
   assign rsp_entry_count = rsp_cnt_ff;
   assign rsp_is_empty    = rsp_empty_ff;

   // Occupancy never passes the capacity
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY))
   // Memory writes and count changes happen only in the modify steps
   `ASSERT_IMPLY(a_write_step, clock, reset, ram_we, state_ff == ST_ACT || state_ff == ST_ERASE_WR)
   `ASSERT_NEXT(a_count_hold, clock, reset, state_ff != ST_ACT && state_ff != ST_ERASE_WR, $stable(count_ff))
   // A new response comes only out of the result step
   `ASSERT_IMPLY(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE)

endmodule

`default_nettype wire

// File: hw/rtl/kvt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module kvt_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 256,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry through a registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: verif/kvt_table_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the key/value table, keeps a shadow copy of the
// packed pair store and compares every response, field by field, in order.
module kvt_table_checker #(
   parameter int unsigned CAPACITY = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  kvt_pkg::op_type                     req_op,
   input  logic [kvt_pkg::KEY_PORT_BITS-1:0]   req_key_in,
   input  logic [kvt_pkg::VALUE_PORT_BITS-1:0] req_value_in,
   input  logic [kvt_pkg::SLOT_PORT_BITS-1:0]  req_slot_index,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic                                rsp_ok,
   input  logic [kvt_pkg::KEY_PORT_BITS-1:0]   rsp_key_out,
   input  logic [kvt_pkg::VALUE_PORT_BITS-1:0] rsp_value_out,
   input  logic [kvt_pkg::COUNT_PORT_BITS-1:0] rsp_entry_count,
   input  logic                                rsp_is_empty,
   output int                                  mismatch_count,
   output int                                  outstanding
);

   import kvt_pkg::*;

   typedef struct packed {
      logic                       ok;
      logic [KEY_PORT_BITS-1:0]   key_out;
      logic [VALUE_PORT_BITS-1:0] value_out;
      logic [COUNT_PORT_BITS-1:0] count;
      logic                       empty;
   } table_rsp_type;

   logic [KEY_PORT_BITS-1:0]   shadow_keys [CAPACITY];
   logic [VALUE_PORT_BITS-1:0] shadow_vals [CAPACITY];
   int                         shadow_fill;
   table_rsp_type              expected_rsp_q [$];

   // Return the first packed slot holding the key, or -1 on a miss
   function automatic int lookup_slot(logic [KEY_PORT_BITS-1:0] key);
      for (int s = 0; s < shadow_fill; s++) begin
         if (shadow_keys[s] == key) return s;
      end
      return -1;
   endfunction

   // Append a pair at the end of the packed region unless the table is full
   function automatic logic append_pair(logic [KEY_PORT_BITS-1:0] key,
                                        logic [VALUE_PORT_BITS-1:0] value);
      if (shadow_fill >= int'(CAPACITY)) return 1'b0;
      shadow_keys[shadow_fill] = key;
      shadow_vals[shadow_fill] = value;
      shadow_fill++;
      return 1'b1;
   endfunction

   // Apply one request to the shadow table and build the response it must produce
   function automatic table_rsp_type apply_table_op(op_type op,
                                                    logic [KEY_PORT_BITS-1:0] key,
                                                    logic [VALUE_PORT_BITS-1:0] value,
                                                    logic [SLOT_PORT_BITS-1:0] slot);
      table_rsp_type rsp;
      int            hit;
      rsp = '0;
      hit = lookup_slot(key);
      case (op)
         OP_INSERT: begin
            if (hit < 0) rsp.ok = append_pair(key, value);
         end
         OP_UPDATE: begin
            if (hit >= 0) begin
               shadow_vals[hit] = value;
               rsp.ok = 1'b1;
            end
         end
         OP_UPSERT: begin
            if (hit >= 0) begin
               shadow_vals[hit] = value;
               rsp.ok = 1'b1;
            end else begin
               rsp.ok = append_pair(key, value);
            end
         end
         OP_ERASE: begin
            // fill the freed slot with the last pair to keep the table packed
            if (hit >= 0) begin
               shadow_keys[hit] = shadow_keys[shadow_fill-1];
               shadow_vals[hit] = shadow_vals[shadow_fill-1];
               shadow_fill--;
               rsp.ok = 1'b1;
            end
         end
         OP_CONTAINS: begin
            rsp.ok = (hit >= 0);
         end
         OP_GET_KEY: begin
            if (hit >= 0) begin
               rsp.ok = 1'b1;
               rsp.value_out = shadow_vals[hit];
            end
         end
         OP_GET_SLOT: begin
            if (int'(slot) < shadow_fill) begin
               rsp.ok = 1'b1;
               rsp.key_out = shadow_keys[slot];
               rsp.value_out = shadow_vals[slot];
            end
         end
         default: begin
         end
      endcase
      rsp.count = shadow_fill[COUNT_PORT_BITS-1:0];
      rsp.empty = (shadow_fill == 0);
      return rsp;
   endfunction

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // Queue a prediction per accepted request, compare per accepted response
   always @(posedge clock) begin : monitor
      table_rsp_type oldest;
      if (reset) begin
         shadow_fill = 0;
         mismatch_count = 0;
         outstanding = 0;
         expected_rsp_q.delete();
      end else begin
         if (req_valid && req_ready) begin
            expected_rsp_q.push_back(apply_table_op(req_op, req_key_in, req_value_in,
                                                    req_slot_index));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: response transaction with no request waiting", $time);
               mismatch_count++;
            end else begin
               oldest = expected_rsp_q.pop_front();
               check_field("ok", 32'(oldest.ok), 32'(rsp_ok));
               check_field("key_out", oldest.key_out, rsp_key_out);
               check_field("value_out", oldest.value_out, rsp_value_out);
               check_field("entry_count", 32'(oldest.count), 32'(rsp_entry_count));
               check_field("is_empty", 32'(oldest.empty), 32'(rsp_is_empty));
            end
         end
         outstanding = expected_rsp_q.size();
      end
   end

endmodule

// File: verif/key_value_table_core_test.sv
`timescale 1ns / 1ps

module key_value_table_core_test;
   import kvt_pkg::*;

   localparam int     TABLE_SLOTS     = 256;
   localparam int     HOLD_OFF_CYCLES = 600;
   localparam op_type OP_UNUSED       = op_type'(3'd7);

   logic                       clock          = 1'b0;
   logic                       reset          = 1'b1;
   logic                       req_valid      = 1'b0;
   logic                       req_ready;
   op_type                     req_op         = OP_CONTAINS;
   logic [KEY_PORT_BITS-1:0]   req_key_in     = '0;
   logic [VALUE_PORT_BITS-1:0] req_value_in   = '0;
   logic [SLOT_PORT_BITS-1:0]  req_slot_index = '0;
   logic                       rsp_valid;
   logic                       rsp_ready      = 1'b0;
   logic                       rsp_ok;
   logic [KEY_PORT_BITS-1:0]   rsp_key_out;
   logic [VALUE_PORT_BITS-1:0] rsp_value_out;
   logic [COUNT_PORT_BITS-1:0] rsp_entry_count;
   logic                       rsp_is_empty;
   int                         mismatch_count;
   int                         outstanding;

   int                         send_idle_pct  = 0;
   int                         rsp_stall_pct  = 0;
   int                         hold_requests  = 0;
   logic [KEY_PORT_BITS-1:0]   key_pool [$];

   key_value_table_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_key_in      (req_key_in),
      .req_value_in    (req_value_in),
      .req_slot_index  (req_slot_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ok          (rsp_ok),
      .rsp_key_out     (rsp_key_out),
      .rsp_value_out   (rsp_value_out),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

   kvt_table_checker #(.CAPACITY(TABLE_SLOTS)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_key_in      (req_key_in),
      .req_value_in    (req_value_in),
      .req_slot_index  (req_slot_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ok          (rsp_ok),
      .rsp_key_out     (rsp_key_out),
      .rsp_value_out   (rsp_value_out),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .mismatch_count  (mismatch_count),
      .outstanding     (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Bound the run in case the block hangs
   initial begin
      #60_000_000;
      $display("tb: failure");
      $finish;
   end

   // Drive response ready: random stalls, plus a long hold-off on request
   initial begin : response_drain
      int hold_left;
      int holds_seen;
      hold_left = 0;
      holds_seen = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_seen) begin
            holds_seen = hold_requests;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // Offer one request transaction, hold it until accepted, then maybe idle
   task automatic send_request(op_type op, logic [KEY_PORT_BITS-1:0] key,
                               logic [VALUE_PORT_BITS-1:0] value,
                               logic [SLOT_PORT_BITS-1:0] slot);
      req_valid <= 1'b1;
      req_op <= op;
      req_key_in <= key;
      req_value_in <= value;
      req_slot_index <= slot;
      do @(posedge clock); while (!req_ready);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic set_idling(int send_pct, int stall_pct);
      send_idle_pct <= send_pct;
      rsp_stall_pct <= stall_pct;
   endtask

   // Drop valid and wait until every predicted response has come back
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      @(posedge clock);
   endtask

   function automatic op_type pick_op();
      int roll = $urandom_range(0, 99);
      if (roll < 20) return OP_INSERT;
      if (roll < 32) return OP_UPDATE;
      if (roll < 47) return OP_UPSERT;
      if (roll < 62) return OP_ERASE;
      if (roll < 74) return OP_CONTAINS;
      if (roll < 86) return OP_GET_KEY;
      if (roll < 98) return OP_GET_SLOT;
      return OP_UNUSED;
   endfunction

   // Mostly keys from the pool so that hits are common, some fresh misses
   function automatic logic [KEY_PORT_BITS-1:0] pick_key();
      if (key_pool.size() == 0 || $urandom_range(0, 99) < 15) return $urandom();
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
   endfunction

   function automatic logic [SLOT_PORT_BITS-1:0] pick_slot();
      if ($urandom_range(0, 99) < 70) return SLOT_PORT_BITS'($urandom_range(0, 63));
      return SLOT_PORT_BITS'($urandom_range(0, 255));
   endfunction

   task automatic random_ops(int num_items);
      for (int i = 0; i < num_items; i++) begin
         send_request(pick_op(), pick_key(), $urandom(), pick_slot());
      end
   endtask

   // Build a small key pool including the extreme keys, then run a random mix
   task automatic random_burst(int num_items, int pool_size);
      key_pool.delete();
      key_pool.push_back('0);
      key_pool.push_back('1);
      for (int i = 2; i < pool_size; i++) key_pool.push_back($urandom());
      random_ops(num_items);
   endtask

   // Fill the table past capacity, exercise it full, then erase every pooled key
   task automatic fill_and_drain();
      logic [KEY_PORT_BITS-1:0] tmp;
      int                       j;
      key_pool.delete();
      for (int i = 0; i < TABLE_SLOTS + 14; i++) key_pool.push_back($urandom());
      foreach (key_pool[i]) begin
         send_request(($urandom_range(0, 1) != 0) ? OP_UPSERT : OP_INSERT, key_pool[i],
                      $urandom(), '0);
      end
      random_ops(40);
      // shuffle so that erases hit slots all over the packed region
      for (int i = key_pool.size() - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = key_pool[i];
         key_pool[i] = key_pool[j];
         key_pool[j] = tmp;
      end
      foreach (key_pool[i]) begin
         send_request(OP_ERASE, key_pool[i], $urandom(), '0);
         if ($urandom_range(0, 99) < 20) begin
            send_request(pick_op(), pick_key(), $urandom(), pick_slot());
         end
      end
   endtask

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Misses on an empty table
      send_request(OP_CONTAINS, '0, '0, '0);
      send_request(OP_GET_SLOT, '0, '0, '0);
      send_request(OP_ERASE, '1, '0, '0);
      send_request(OP_UPDATE, '0, '1, '0);
      send_request(OP_GET_KEY, '1, '1, '0);
      // Extreme keys and values, duplicate insert, both upsert paths
      send_request(OP_INSERT, '0, '1, '0);
      send_request(OP_INSERT, '1, '0, '0);
      send_request(OP_INSERT, '0, 32'h1234_5678, '0);
      send_request(OP_UPSERT, '0, 32'h1234_5678, '0);
      send_request(OP_UPSERT, 32'hA5A5_A5A5, 32'h5A5A_5A5A, '0);
      send_request(OP_GET_KEY, '1, '0, '0);
      send_request(OP_GET_SLOT, '0, '0, 8'd0);
      send_request(OP_GET_SLOT, '0, '0, 8'd2);
      send_request(OP_GET_SLOT, '0, '0, 8'd3);
      send_request(OP_GET_SLOT, '1, '1, '1);
      send_request(OP_CONTAINS, 32'hA5A5_A5A5, '0, '0);
      send_request(OP_UPDATE, '1, 32'hAAAA_AAAA, '0);
      // Erase the first pair so the last one moves down
      send_request(OP_ERASE, '0, '0, '0);
      send_request(OP_GET_SLOT, '0, '0, 8'd0);
      send_request(OP_UNUSED, '1, '1, '1);
      send_request(OP_ERASE, 32'hA5A5_A5A5, '0, '0);
      send_request(OP_ERASE, '1, '0, '0);
      send_request(OP_GET_KEY, '1, '0, '0);

      set_idling(0, 0);
      random_burst(300, 40);

      // Long response hold-off while requests keep coming
      hold_requests <= hold_requests + 1;
      random_burst(200, 16);
      drain_responses();

      set_idling(52, 0);
      random_burst(300, 48);

      set_idling(0, 52);
      fill_and_drain();

      set_idling(16, 16);
      random_burst(300, 64);

      set_idling(0, 0);
      random_burst(200, 24);

      drain_responses();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
